// ===== hdl/gdi_pkg.sv =====
// ----------------------------------------------------------------------------
// gdi_pkg
// Types and constants shared by the gyro dead-band integrator modules.
// ----------------------------------------------------------------------------
package gdi_pkg;

   // number of axis lanes carried in the payloads
   localparam int MAX_AXES = 3;

   // depth of the queue between the front and the back
   localparam int QUEUE_DEPTH = 2;

   // field widths
   localparam int RAW_W   = 16;
   localparam int ABS_W   = RAW_W + 1;
   localparam int SCALE_W = 16;
   localparam int MAG_W   = ABS_W + SCALE_W;
   localparam int FRAC_W  = 16;
   localparam int WHOLE_W = MAG_W - FRAC_W;
   localparam int ACC_W   = 32;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   // item modes
   localparam logic [1:0] MODE_CAL    = 2'd0;
   localparam logic [1:0] MODE_MEAS   = 2'd1;
   localparam logic [1:0] MODE_FINISH = 2'd2;

   // control register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_RATE_SCALE  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_NOISE_CEIL  = 2'd1;

   // control register reset values
   localparam logic [SCALE_W-1:0]    RATE_SCALE_RESET = 16'd459;
   localparam logic [CSR_DATA_W-1:0] NOISE_CEIL_RESET = 16'd100;

   // saturation value of a threshold
   localparam logic [MAG_W-1:0] THR_MAX = {MAG_W{1'b1}};

   typedef struct packed {
      logic [1:0]              mode;
      logic signed [RAW_W-1:0] x_raw;
      logic signed [RAW_W-1:0] y_raw;
      logic signed [RAW_W-1:0] z_raw;
   } req_type;

   typedef struct packed {
      logic signed [ACC_W-1:0] x_angle;
      logic signed [ACC_W-1:0] y_angle;
      logic signed [ACC_W-1:0] z_angle;
      logic                    is_calibrated;
   } rsp_type;

   // classified item handed from the front to the back
   typedef struct packed {
      logic [1:0]                        mode;
      logic [MAX_AXES-1:0]               neg;
      logic [MAX_AXES-1:0][MAG_W-1:0]    mag;
   } entry_type;

   // queue status seen by the top level
   typedef struct packed {
      logic [$clog2(QUEUE_DEPTH+1)-1:0] count;
      logic                             full;
      logic                             pop;
   } queue_status_type;

endpackage

// ===== hdl/gdi_front.sv =====
// ----------------------------------------------------------------------------
// gdi_front
// Front end: takes the absolute value of each raw sample and scales it to a
// rate magnitude with 16 fraction bits, keeping the sign for the back end.
// ----------------------------------------------------------------------------
module gdi_front (
   input  gdi_pkg::req_type                 req_data,
   input  logic [gdi_pkg::SCALE_W-1:0]      rate_scale,
   output gdi_pkg::entry_type               entry
);

   logic [gdi_pkg::MAX_AXES-1:0][gdi_pkg::RAW_W-1:0] raw;
   logic [gdi_pkg::MAX_AXES-1:0][gdi_pkg::ABS_W-1:0] abs_val;
   logic [gdi_pkg::MAX_AXES-1:0][gdi_pkg::ABS_W-1:0] ext;

   // axis lanes in order x, y, z
   assign raw[0] = req_data.x_raw;
   assign raw[1] = req_data.y_raw;
   assign raw[2] = req_data.z_raw;

   // sign, magnitude and scaling, one multiplier per axis
   always_comb begin
      entry.mode = req_data.mode;
      for (int i = 0; i < gdi_pkg::MAX_AXES; i++) begin
         ext[i]       = {raw[i][gdi_pkg::RAW_W-1], raw[i]};
         entry.neg[i] = raw[i][gdi_pkg::RAW_W-1];
         abs_val[i]   = entry.neg[i] ? gdi_pkg::ABS_W'(~ext[i] + 1'b1) : ext[i];
         entry.mag[i] = gdi_pkg::MAG_W'(abs_val[i]) * gdi_pkg::MAG_W'(rate_scale);
      end
   end

endmodule

// ===== hdl/gdi_queue.sv =====
// ----------------------------------------------------------------------------
// gdi_queue
// Two-entry queue between the front and the back, so that each side can
// stall on its own.
// ----------------------------------------------------------------------------
module gdi_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  gdi_pkg::entry_type         push_entry,
   input  logic                       pop,
   output logic                       head_valid,
   output gdi_pkg::entry_type         head_entry,
   output gdi_pkg::queue_status_type  status
);

   localparam int PTR_W = $clog2(gdi_pkg::QUEUE_DEPTH);
   localparam int CNT_W = $clog2(gdi_pkg::QUEUE_DEPTH + 1);

   gdi_pkg::entry_type slot_ff [gdi_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(gdi_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(gdi_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   assign head_valid   = (count_ff != '0);
   assign head_entry   = slot_ff[rd_ptr_ff];
   assign status.count = count_ff;
   assign status.full  = (count_ff == CNT_W'(gdi_pkg::QUEUE_DEPTH));
   assign status.pop   = pop;

endmodule

// ===== hdl/gdi_back.sv =====
// ----------------------------------------------------------------------------
// gdi_back
// Back end: applies one classified item to the thresholds, accumulators and
// calibrated flag, and holds the result in the output register.
// ----------------------------------------------------------------------------
module gdi_back #(
   parameter int AXIS_COUNT = 3
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           head_valid,
   input  gdi_pkg::entry_type             head_entry,
   output logic                           pop,
   input  logic [gdi_pkg::CSR_DATA_W-1:0] noise_ceiling,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output gdi_pkg::rsp_type               rsp_data,
   output logic                           cal_flag
);

   localparam int MAG_W = gdi_pkg::MAG_W;
   localparam int ACC_W = gdi_pkg::ACC_W;

   logic [gdi_pkg::MAX_AXES-1:0][MAG_W-1:0] thr_ff, thr_in;
   logic [gdi_pkg::MAX_AXES-1:0][ACC_W-1:0] acc_ff, acc_in;
   logic                                    cal_ff, cal_in;
   logic                                    rsp_valid_ff, rsp_valid_in;
   gdi_pkg::rsp_type                        rsp_data_ff, rsp_data_in;

   logic [MAG_W-1:0]                              ceil_mag;
   logic [gdi_pkg::MAX_AXES-1:0][MAG_W:0]         thr_dbl;
   logic [gdi_pkg::MAX_AXES-1:0][ACC_W-1:0]       whole;

   // take the head item when the output register is free or being emptied
   assign pop = head_valid && (!rsp_valid_ff || !rsp_stall);

   assign ceil_mag = {1'b0, noise_ceiling, gdi_pkg::FRAC_W'(0)};

   // per-axis threshold and accumulator update
   always_comb begin
      thr_in = thr_ff;
      acc_in = acc_ff;
      cal_in = cal_ff;
      for (int i = 0; i < gdi_pkg::MAX_AXES; i++) begin
         thr_dbl[i] = {thr_ff[i], 1'b0};
         whole[i]   = ACC_W'(head_entry.mag[i][MAG_W-1:gdi_pkg::FRAC_W]);
         if (pop && (i < AXIS_COUNT)) begin
            case (head_entry.mode)
               gdi_pkg::MODE_CAL: begin
                  if ((head_entry.mag[i] > thr_ff[i]) && (head_entry.mag[i] < ceil_mag)) begin
                     thr_in[i] = head_entry.mag[i];
                  end
               end
               gdi_pkg::MODE_MEAS: begin
                  if (head_entry.mag[i] > thr_ff[i]) begin
                     acc_in[i] = head_entry.neg[i] ? acc_ff[i] - whole[i]
                                                   : acc_ff[i] + whole[i];
                  end
               end
               gdi_pkg::MODE_FINISH: begin
                  thr_in[i] = thr_dbl[i][MAG_W] ? gdi_pkg::THR_MAX : thr_dbl[i][MAG_W-1:0];
               end
               default: begin
               end
            endcase
         end
      end
      if (pop && (head_entry.mode == gdi_pkg::MODE_FINISH)) begin
         cal_in = 1'b1;
      end
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (pop) begin
         rsp_valid_in              = 1'b1;
         rsp_data_in.x_angle       = acc_in[0];
         rsp_data_in.y_angle       = acc_in[1];
         rsp_data_in.z_angle       = acc_in[2];
         rsp_data_in.is_calibrated = cal_in;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff       <= '0;
         acc_ff       <= '0;
         cal_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         thr_ff       <= thr_in;
         acc_ff       <= acc_in;
         cal_ff       <= cal_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign cal_flag  = cal_ff;

endmodule

// ===== hdl/gyro_deadband_integrator.sv =====
// ----------------------------------------------------------------------------
// gyro_deadband_integrator
// Three-axis gyro rate integrator with a calibrated dead band.
//
//   channel  direction  handshake          payload
//   req      in         req_valid/stall    gdi_pkg::req_type
//   rsp      out        rsp_valid/stall    gdi_pkg::rsp_type
//   csr      in         csr_valid/ready    csr_index, csr_wdata
//
// One transaction per cycle sustained while req_stall and rsp_stall stay low; a
// result passes the queue slot and then the output register when the output is
// free (front multiplier into the queue, back update into the output register).
// Reset is synchronous and clears thresholds, accumulators, flag and the
// control registers to their reset values.
// rsp_stall holds the output register; the two-entry queue absorbs the
// front while the back waits, and req_stall rises only when the queue is full.
// ----------------------------------------------------------------------------
module gyro_deadband_integrator #(
   parameter int AXIS_COUNT = 3
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  gdi_pkg::req_type                  req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output gdi_pkg::rsp_type                  rsp_data,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [gdi_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [gdi_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   logic [gdi_pkg::SCALE_W-1:0]    rate_scale_ff, rate_scale_in;
   logic [gdi_pkg::CSR_DATA_W-1:0] noise_ceil_ff, noise_ceil_in;

   gdi_pkg::entry_type             front_entry;
   gdi_pkg::entry_type             head_entry;
   gdi_pkg::queue_status_type      q_status;
   logic                           push;
   logic                           head_valid;
   logic                           pop;
   logic                           cal_flag;

   // control registers
   assign csr_ready = 1'b1;

   always_comb begin
      rate_scale_in = rate_scale_ff;
      noise_ceil_in = noise_ceil_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            gdi_pkg::CSR_RATE_SCALE: rate_scale_in = csr_wdata;
            gdi_pkg::CSR_NOISE_CEIL: noise_ceil_in = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rate_scale_ff <= gdi_pkg::RATE_SCALE_RESET;
         noise_ceil_ff <= gdi_pkg::NOISE_CEIL_RESET;
      end else begin
         rate_scale_ff <= rate_scale_in;
         noise_ceil_ff <= noise_ceil_in;
      end
   end

   // front: classify and scale
   gdi_front u_front (
      .req_data   (req_data),
      .rate_scale (rate_scale_ff),
      .entry      (front_entry)
   );

   assign req_stall = q_status.full;
   assign push      = req_valid && !req_stall;

   // queue between front and back
   gdi_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (front_entry),
      .pop        (pop),
      .head_valid (head_valid),
      .head_entry (head_entry),
      .status     (q_status)
   );

   // back: state update and result register
   gdi_back #(
      .AXIS_COUNT (AXIS_COUNT)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .head_valid    (head_valid),
      .head_entry    (head_entry),
      .pop           (pop),
      .noise_ceiling (noise_ceil_ff),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_data      (rsp_data),
      .cal_flag      (cal_flag)
   );

`ifndef SYNTHESIS
   // the back never takes from an empty queue
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      q_status.pop |-> (q_status.count != '0))
      else $error("pop from empty queue");

   // fill count stays within the queue depth
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      q_status.count <= ($bits(q_status.count))'(gdi_pkg::QUEUE_DEPTH))
      else $error("queue count overflow");

   // the calibrated flag is sticky
   a_cal_sticky: assert property (@(posedge clock) disable iff (reset)
      cal_flag |=> cal_flag)
      else $error("calibrated flag cleared");

   // an item entering an idle block passes the queue and then the output register
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (push && (q_status.count == '0) && !rsp_valid) |=> ##1 rsp_valid)
      else $error("result missing after idle accept");
`endif

endmodule

// ===== tb/sv/tb_gyro_deadband_integrator.sv =====
// ----------------------------------------------------------------------------
// tb_gyro_deadband_integrator
// Self-checking bench for the gyro dead-band integrator. Samples are sent on
// the req channel while a built-in predictor tracks thresholds, accumulators
// and the calibrated flag. Every rsp transaction is compared field by field
// with the oldest predicted angle set. Directed tests cover power-on behavior,
// calibration peaks, register extremes, full-scale runs and threshold
// saturation. Random phases add sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module tb_gyro_deadband_integrator;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_AXES   = gdi_pkg::MAX_AXES;
   localparam int RAW_W      = gdi_pkg::RAW_W;
   localparam int ABS_W      = gdi_pkg::ABS_W;
   localparam int MAG_W      = gdi_pkg::MAG_W;
   localparam int FRAC_W     = gdi_pkg::FRAC_W;
   localparam int ACC_W      = gdi_pkg::ACC_W;
   localparam int SCALE_W    = gdi_pkg::SCALE_W;
   localparam int CSR_IDX_W  = gdi_pkg::CSR_IDX_W;
   localparam int CSR_DATA_W = gdi_pkg::CSR_DATA_W;

   localparam int CLK_PERIOD       = 12;
   localparam int RESET_CYCLES     = 7;
   localparam int WATCHDOG_LIMIT   = 2000;
   localparam int SETTLE_CYCLES    = 4;
   localparam int END_CYCLES       = 8;
   localparam int PHASE_ITEMS      = 165;
   localparam int FULL_SCALE_ITEMS = 32;
   localparam int FINISH_REPEATS   = 4;
   localparam logic [1:0] MODE_UNUSED = 2'd3;

   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  req_valid   = 1'b0;
   logic                  req_stall;
   gdi_pkg::req_type      req_data    = '0;
   logic                  rsp_valid;
   logic                  rsp_stall   = 1'b0;
   gdi_pkg::rsp_type      rsp_data;
   logic                  csr_valid   = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index   = '0;
   logic [CSR_DATA_W-1:0] csr_wdata   = '0;

   // predictor state
   logic [MAG_W-1:0]      axis_thr [MAX_AXES];
   logic [ACC_W-1:0]      axis_sum [MAX_AXES];
   logic                  cal_done;
   logic [SCALE_W-1:0]    scale_reg;
   logic [CSR_DATA_W-1:0] ceil_reg;

   gdi_pkg::rsp_type angle_q[$];
   int      fail_count     = 0;
   int      send_idle_pct  = 0;
   int      recv_stall_pct = 0;
   int      quiet_cycles   = 0;

   gyro_deadband_integrator dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      forever #(CLK_PERIOD / 2) clock = ~clock;
   end

   // integrate one sample and return the angles it leaves behind
   function automatic gdi_pkg::rsp_type predict_integrator(input gdi_pkg::req_type item);
      logic [RAW_W-1:0] raw [MAX_AXES];
      logic [ABS_W-1:0] mag_abs;
      logic [MAG_W-1:0] mag;
      logic [MAG_W:0]   doubled;
      logic             neg;
      gdi_pkg::rsp_type r;
      int               i;
      raw[0] = item.x_raw;
      raw[1] = item.y_raw;
      raw[2] = item.z_raw;
      for (i = 0; i < MAX_AXES; i++) begin
         neg     = raw[i][RAW_W-1];
         mag_abs = neg ? (ABS_W'(1) << RAW_W) - ABS_W'(raw[i]) : ABS_W'(raw[i]);
         mag     = MAG_W'(mag_abs) * MAG_W'(scale_reg);
         case (item.mode)
            gdi_pkg::MODE_CAL: begin
               if (mag > axis_thr[i] && mag < MAG_W'({ceil_reg, FRAC_W'(0)}))
                  axis_thr[i] = mag;
            end
            gdi_pkg::MODE_MEAS: begin
               if (mag > axis_thr[i]) begin
                  if (neg)
                     axis_sum[i] = axis_sum[i] - ACC_W'(mag[MAG_W-1:FRAC_W]);
                  else
                     axis_sum[i] = axis_sum[i] + ACC_W'(mag[MAG_W-1:FRAC_W]);
               end
            end
            gdi_pkg::MODE_FINISH: begin
               doubled     = {axis_thr[i], 1'b0};
               axis_thr[i] = (doubled > (MAG_W+1)'(gdi_pkg::THR_MAX)) ? gdi_pkg::THR_MAX
                                                                      : doubled[MAG_W-1:0];
            end
            default: ;
         endcase
      end
      if (item.mode == gdi_pkg::MODE_FINISH)
         cal_done = 1'b1;
      r.x_angle       = axis_sum[0];
      r.y_angle       = axis_sum[1];
      r.z_angle       = axis_sum[2];
      r.is_calibrated = cal_done;
      return r;
   endfunction

   function automatic gdi_pkg::req_type make_sample(input logic [1:0] mode,
                                                    input logic [RAW_W-1:0] x, y, z);
      gdi_pkg::req_type s;
      s.mode  = mode;
      s.x_raw = x;
      s.y_raw = y;
      s.z_raw = z;
      return s;
   endfunction

   // random raw value over the full range
   function automatic logic [RAW_W-1:0] any_raw();
      return RAW_W'($urandom);
   endfunction

   // signed value in [-span, span]
   function automatic logic [RAW_W-1:0] small_raw(input int span);
      return RAW_W'(int'($urandom_range(2 * span)) - span);
   endfunction

   function automatic logic [RAW_W-1:0] extreme_raw();
      case ($urandom_range(4))
         0:       return 16'h7FFF;
         1:       return 16'h8000;
         2:       return 16'h0000;
         3:       return 16'h0001;
         default: return 16'hFFFF;
      endcase
   endfunction

   function automatic logic [RAW_W-1:0] measure_raw();
      case ($urandom_range(3))
         0, 1:    return any_raw();
         2:       return small_raw(2000);
         default: return extreme_raw();
      endcase
   endfunction

   // send one sample, with random idle cycles ahead of it
   task automatic send_sample(input gdi_pkg::req_type item);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         req_data  <= make_sample(2'($urandom), any_raw(), any_raw(), any_raw());
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      angle_q.push_back(predict_integrator(item));
   endtask

   // hold off the sender until every predicted result has come back
   task automatic wait_for_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (angle_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         gdi_pkg::CSR_RATE_SCALE: scale_reg = value;
         gdi_pkg::CSR_NOISE_CEIL: ceil_reg  = value;
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // registers only change with the pipeline empty
   task automatic configure(input logic [CSR_DATA_W-1:0] scale,
                            input logic [CSR_DATA_W-1:0] ceiling);
      wait_for_results();
      write_reg(gdi_pkg::CSR_RATE_SCALE, scale);
      write_reg(gdi_pkg::CSR_NOISE_CEIL, ceiling);
   endtask

   // reset values, zero thresholds, extremes and the unused mode
   task automatic test_power_on();
      send_sample(make_sample(gdi_pkg::MODE_MEAS, 16'h7FFF, 16'h8000, 16'h0000));
      send_sample(make_sample(gdi_pkg::MODE_MEAS, 16'h0001, 16'hFFFF, 16'h0000));
      send_sample(make_sample(gdi_pkg::MODE_MEAS, 16'd143, -16'sd143, 16'd142));
      send_sample(make_sample(MODE_UNUSED, 16'h7FFF, 16'h8000, 16'hFFFF));
      send_sample(make_sample(gdi_pkg::MODE_FINISH, 16'h0000, 16'h0000, 16'h0000));
      send_sample(make_sample(gdi_pkg::MODE_FINISH, 16'hFFFF, 16'h8000, 16'h7FFF));
      send_sample(make_sample(gdi_pkg::MODE_MEAS, 16'h8000, 16'h7FFF, 16'hFFFF));
   endtask

   // peak tracking below the ceiling, calibration after a finish, doubling
   task automatic test_calibration_peaks();
      send_sample(make_sample(gdi_pkg::MODE_CAL, 16'd100, -16'sd100, 16'd50));
      send_sample(make_sample(gdi_pkg::MODE_CAL, -16'sd200, 16'd20, 16'd0));
      send_sample(make_sample(gdi_pkg::MODE_CAL, 16'd10, 16'd10, 16'd10));
      send_sample(make_sample(gdi_pkg::MODE_CAL, 16'd14277, -16'sd14278, 16'd14300));
      send_sample(make_sample(gdi_pkg::MODE_MEAS, 16'd14277, -16'sd14278, 16'd201));
      send_sample(make_sample(gdi_pkg::MODE_MEAS, 16'd14278, -16'sd14276, -16'sd202));
      send_sample(make_sample(gdi_pkg::MODE_FINISH, 16'd0, 16'd0, 16'd0));
      send_sample(make_sample(gdi_pkg::MODE_MEAS, 16'd28554, -16'sd28555, 16'd200));
      send_sample(make_sample(gdi_pkg::MODE_MEAS, 16'd28555, -16'sd28556, 16'h8000));
   endtask

   // both registers at their limits
   task automatic test_register_extremes();
      configure(16'h0000, 16'h0000);
      send_sample(make_sample(gdi_pkg::MODE_MEAS, 16'h7FFF, 16'h8000, 16'h5555));
      send_sample(make_sample(gdi_pkg::MODE_CAL, 16'h7FFF, 16'h8000, 16'hAAAA));
      configure(16'hFFFF, 16'hFFFF);
      send_sample(make_sample(gdi_pkg::MODE_MEAS, 16'h7FFF, 16'h8000, 16'hFFFF));
      send_sample(make_sample(gdi_pkg::MODE_CAL, 16'd3, -16'sd3, 16'd3));
      send_sample(make_sample(gdi_pkg::MODE_MEAS, 16'h8000, 16'h7FFF, 16'h0001));
   endtask

   // full-scale rates back to back, negative lanes run through zero
   task automatic test_full_scale();
      configure(16'hFFFF, 16'hFFFF);
      repeat (FULL_SCALE_ITEMS)
         send_sample(make_sample(gdi_pkg::MODE_MEAS, 16'h7FFF, 16'h8000, any_raw()));
   endtask

   // short calibration, then mostly measurement with some noise
   task automatic run_random_phase(input int send_pct, input int recv_pct,
                                   input logic [CSR_DATA_W-1:0] scale,
                                   input logic [CSR_DATA_W-1:0] ceiling);
      int sent;
      int pick;
      configure(scale, ceiling);
      send_idle_pct  = send_pct;
      recv_stall_pct = recv_pct;
      repeat ($urandom_range(3, 8))
         send_sample(make_sample(gdi_pkg::MODE_CAL, small_raw(16), small_raw(16),
                                 small_raw(16)));
      send_sample(make_sample(gdi_pkg::MODE_FINISH, any_raw(), any_raw(), any_raw()));
      sent = 0;
      while (sent < PHASE_ITEMS) begin
         pick = $urandom_range(99);
         if (pick < 2) begin
            wait_for_results();
         end else begin
            if (pick < 72)
               send_sample(make_sample(gdi_pkg::MODE_MEAS, measure_raw(), measure_raw(),
                                       measure_raw()));
            else if (pick < 82)
               send_sample(make_sample(gdi_pkg::MODE_CAL, small_raw(64), small_raw(64),
                                       small_raw(64)));
            else if (pick < 88)
               send_sample(make_sample(MODE_UNUSED, any_raw(), any_raw(), any_raw()));
            else if (pick < 89)
               send_sample(make_sample(gdi_pkg::MODE_FINISH, any_raw(), any_raw(),
                                       any_raw()));
            else
               send_sample(make_sample(gdi_pkg::MODE_MEAS, extreme_raw(), extreme_raw(),
                                       extreme_raw()));
            sent++;
         end
      end
   endtask

   task automatic test_random_traffic();
      run_random_phase(0, 0, gdi_pkg::RATE_SCALE_RESET, gdi_pkg::NOISE_CEIL_RESET);
      run_random_phase(65, 0, 16'hFFFF, 16'hFFFF);
      run_random_phase(0, 65, 16'($urandom), 16'($urandom));
      run_random_phase(23, 23, 16'($urandom), 16'($urandom));
   endtask

   // repeated finishes drive thresholds to their saturation value
   task automatic test_threshold_saturation();
      configure(16'hFFFF, 16'hFFFF);
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      send_sample(make_sample(gdi_pkg::MODE_CAL, 16'h7FFF, 16'h8001, 16'h7FFF));
      repeat (FINISH_REPEATS)
         send_sample(make_sample(gdi_pkg::MODE_FINISH, 16'h0000, 16'h0000, 16'h0000));
      send_sample(make_sample(gdi_pkg::MODE_MEAS, 16'h7FFF, 16'h8000, 16'h8000));
      send_sample(make_sample(gdi_pkg::MODE_CAL, 16'h7FFF, 16'h8000, 16'h0001));
      send_sample(make_sample(MODE_UNUSED, 16'h0000, 16'h0000, 16'h0000));
   endtask

   // stimulus sequence
   initial begin
      for (int i = 0; i < MAX_AXES; i++) begin
         axis_thr[i] = '0;
         axis_sum[i] = '0;
      end
      cal_done  = 1'b0;
      scale_reg = gdi_pkg::RATE_SCALE_RESET;
      ceil_reg  = gdi_pkg::NOISE_CEIL_RESET;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_power_on();
      test_calibration_peaks();
      test_register_extremes();
      test_full_scale();
      test_random_traffic();
      test_threshold_saturation();
      wait_for_results();
      repeat (END_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

   // receiver back-pressure
   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_stall_pct);
   end

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected %0d actual %0d", name, $signed(want), $signed(got));
         fail_count++;
      end
   endtask

   // compare each rsp transaction with the oldest prediction
   always @(posedge clock) begin : check_angles
      gdi_pkg::rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (angle_q.size() == 0) begin
            $error("rsp transaction with no prediction pending: %p", rsp_data);
            fail_count++;
         end else begin
            want = angle_q.pop_front();
            check_field("x_angle", want.x_angle, rsp_data.x_angle);
            check_field("y_angle", want.y_angle, rsp_data.y_angle);
            check_field("z_angle", want.z_angle, rsp_data.z_angle);
            check_field("is_calibrated", 32'(want.is_calibrated),
                        32'(rsp_data.is_calibrated));
         end
      end
   end

   // watchdog on cycles without any transaction
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
          || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

endmodule
